FILE: rtl/core/sdu_pkg.sv
// Shared types and constants of the scanline delta unfilter.
package sdu_pkg;

  // Line store size and derived widths.
  localparam int unsigned MAX_LINE_BYTES = 4096;
  localparam int unsigned COL_W          = $clog2(MAX_LINE_BYTES);
  localparam int unsigned STRIDE_W       = COL_W + 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINE_PIXELS     = 2'd0;
  localparam logic [1:0] CFG_IMAGE_ROWS      = 2'd1;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd2;

  // Line mode codes as they arrive on the stream.
  localparam logic [7:0] MODE_LEFT    = 8'd1;
  localparam logic [7:0] MODE_UP      = 8'd2;
  localparam logic [7:0] MODE_AVERAGE = 8'd4;

  // Decoded reconstruction kind of one byte.
  typedef enum logic [1:0] {
    KIND_LEFT,
    KIND_UP,
    KIND_AVERAGE,
    KIND_BAD
  } kind_e;

  // One byte on its way from the sequencer to the reconstruction stage.
  typedef struct packed {
    logic [7:0]       data;
    kind_e            kind;
    logic             first_px;
    logic             row0;
    logic [COL_W-1:0] col;
    logic             last;
  } item_t;

endpackage

FILE: rtl/core/sdu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sdu_front.sv
// Configuration registers, line and row counters and line mode decode.
module sdu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic [7:0]          line_mode_i,
  output sdu_pkg::item_t      item_o,
  output logic [1:0]          bpp_idx_o,
  output logic                restart_o
);

  import sdu_pkg::*;

  logic [10:0]         line_pixels_q;
  logic [15:0]         image_rows_q;
  logic [2:0]          bpp_q;
  logic [COL_W-1:0]    col_q, col_d;
  logic [15:0]         row_q, row_d;
  logic [7:0]          mode_q, mode_d;

  logic [2:0]          bpp_eff;
  logic [10:0]         px_eff;
  logic [13:0]         stride_full;
  logic [STRIDE_W-1:0] stride;
  logic [COL_W-1:0]    x;
  logic [STRIDE_W-1:0] x_inc;
  logic                eol;
  logic [15:0]         rows_eff;
  logic [16:0]         row_inc;
  logic [7:0]          mode_cur;
  logic                known_idx;
  kind_e               kind;

  // Configuration writes; a write to a known register restarts the image.
  always_comb begin
    known_idx = 1'b0;
    unique case (cfg_index_i)
      CFG_LINE_PIXELS,
      CFG_IMAGE_ROWS,
      CFG_BYTES_PER_PIXEL: known_idx = 1'b1;
      default:             known_idx = 1'b0;
    endcase
  end

  assign restart_o = cfg_valid_i && known_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pixels_q <= 11'd1;
      image_rows_q  <= 16'd1;
      bpp_q         <= 3'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LINE_PIXELS:     line_pixels_q <= cfg_data_i[10:0];
        CFG_IMAGE_ROWS:      image_rows_q  <= cfg_data_i;
        CFG_BYTES_PER_PIXEL: bpp_q         <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, pixel size is capped at four and a line at 4096 bytes.
  always_comb begin
    if (bpp_q == 3'd0) begin
      bpp_eff = 3'd1;
    end else if (bpp_q > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = bpp_q;
    end
    px_eff      = (line_pixels_q == 11'd0) ? 11'd1 : line_pixels_q;
    stride_full = {3'b000, px_eff} * {11'd0, bpp_eff};
    stride      = (stride_full > 14'(MAX_LINE_BYTES)) ? STRIDE_W'(MAX_LINE_BYTES)
                                                       : stride_full[STRIDE_W-1:0];
    rows_eff    = (image_rows_q == 16'd0) ? 16'd1 : image_rows_q;
  end

  assign bpp_idx_o = 2'(bpp_eff - 3'd1);

  // Column position, end of line and the next row number.
  always_comb begin
    x        = ({1'b0, col_q} >= stride) ? COL_W'(stride - STRIDE_W'(1)) : col_q;
    x_inc    = {1'b0, x} + STRIDE_W'(1);
    eol      = (x_inc >= stride);
    row_inc  = {1'b0, row_q} + 17'd1;
    mode_cur = (x == '0) ? line_mode_i : mode_q;
  end

  // Line mode decode.
  always_comb begin
    unique case (mode_cur)
      MODE_LEFT:    kind = KIND_LEFT;
      MODE_UP:      kind = KIND_UP;
      MODE_AVERAGE: kind = KIND_AVERAGE;
      default:      kind = KIND_BAD;
    endcase
  end

  // The word handed to the reconstruction stage.
  always_comb begin
    item_o.data     = data_byte_i;
    item_o.kind     = kind;
    item_o.first_px = ({{(COL_W-3){1'b0}}, bpp_eff} > x);
    item_o.row0     = (row_q == 16'd0);
    item_o.col      = x;
    item_o.last     = eol;
  end

  // Counter updates.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    mode_d = mode_q;
    if (restart_o) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      mode_d = mode_cur;
      if (eol) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, rows_eff}) ? 16'd0 : row_inc[15:0];
      end else begin
        col_d = x_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      mode_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      mode_q <= mode_d;
    end
  end

  // The counters stay inside the configured geometry.
  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < stride)
    else $error("column counter beyond line length");

  a_row_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < rows_eff)
    else $error("row counter beyond image height");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_o |=> (col_q == '0) && (row_q == 16'd0))
    else $error("restart did not return to row zero, column zero");

endmodule

FILE: rtl/core/sdu_recon.sv
// Item register, byte reconstruction, left history and result register.
module sdu_recon (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  sdu_pkg::item_t       item_i,
  input  logic [1:0]           bpp_idx_i,
  input  logic                 restart_i,
  output logic                 in_ready_o,
  input  logic [7:0]           above_rdata_i,
  output logic                 wr_en_o,
  output logic [sdu_pkg::COL_W-1:0] wr_addr_o,
  output logic [7:0]           wr_data_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           pixel_byte_o,
  output logic                 end_of_line_o,
  output logic                 bad_mode_o
);

  import sdu_pkg::*;

  item_t       s1_q;
  logic        s1_valid_q;
  logic        hit_q;
  logic [7:0]  fwd_q;
  logic [7:0]  hist_q [4];
  logic        out_valid_q;
  logic [7:0]  out_pixel_q;
  logic        out_last_q;
  logic        out_bad_q;

  logic        out_free;
  logic        s1_fire;
  logic [7:0]  above;
  logic [7:0]  left;
  logic [8:0]  sum;
  logic [7:0]  res;

  // Handshake: the item register moves whenever the result register is free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Neighbors: the line above comes from the store, or from the write in flight.
  always_comb begin
    if (s1_q.row0) begin
      above = 8'd0;
    end else if (hit_q) begin
      above = fwd_q;
    end else begin
      above = above_rdata_i;
    end
    left = hist_q[bpp_idx_i];
    sum  = {1'b0, above} + {1'b0, left};
  end

  // Byte reconstruction, modulo 256.
  always_comb begin
    case (s1_q.kind)
      KIND_LEFT:    res = s1_q.first_px ? s1_q.data : 8'(left - s1_q.data);
      KIND_UP:      res = 8'(above - s1_q.data);
      KIND_AVERAGE: res = s1_q.first_px ? s1_q.data : 8'(sum[8:1] - s1_q.data);
      default:      res = 8'd0;
    endcase
  end

  assign wr_en_o   = s1_fire;
  assign wr_addr_o = s1_q.col;
  assign wr_data_o = res;

  // Item register with the forwarding mark for a same-column read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else if (accept_i) begin
      s1_valid_q <= 1'b1;
      hit_q      <= s1_fire && (item_i.col == s1_q.col);
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q  <= item_i;
      fwd_q <= res;
    end
  end

  // Recent reconstructed bytes of the current line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= 8'd0;
      end
    end else if (restart_i) begin
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= 8'd0;
      end
    end else if (s1_fire) begin
      for (int i = 3; i > 0; i--) begin
        hist_q[i] <= hist_q[i-1];
      end
      hist_q[0] <= res;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pixel_q <= res;
      out_last_q  <= s1_q.last;
      out_bad_q   <= (s1_q.kind == KIND_BAD);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_byte_o  = out_pixel_q;
  assign end_of_line_o = out_last_q;
  assign bad_mode_o    = out_bad_q;

  // A bad line mode always yields a zero byte.
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_pixel_q == 8'd0))
    else $error("bad mode result carries a nonzero byte");

  // A byte leaving the item register shows up as a result.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("reconstructed byte was lost");

  // A restart empties the left history.
  a_restart_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (hist_q[0] == 8'd0) && (hist_q[1] == 8'd0) &&
                  (hist_q[2] == 8'd0) && (hist_q[3] == 8'd0))
    else $error("left history not cleared on restart");

endmodule

FILE: rtl/core/scanline_delta_unfilter.sv
// Top level of the scanline delta unfilter.
// Filtered image bytes enter in raster order; each leaves as one reconstructed byte via
// the item and result registers. While the output does not stall, one word enters and
// one byte leaves per clock, limited by the single line-store read and write per byte.
// The previous line is held in a 4096 x 8 RAM with registered read; a byte that reads
// the column written in the same cycle gets the fresh value forwarded. Row zero reads
// an all-zero line above. Any write to a known configuration register restarts the
// image at row zero, column zero, so write configuration only while the block is idle.
module scanline_delta_unfilter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [7:0]  s_axis_tuser,   // [7:0] line_mode
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_byte
  output logic        m_axis_tlast,   // end_of_line
  output logic [0:0]  m_axis_tuser    // [0] bad_mode
);

  import sdu_pkg::*;

  item_t            item;
  logic [1:0]       bpp_idx;
  logic             restart;
  logic             accept;
  logic [7:0]       above_rdata;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             bad_mode;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  // Geometry, counters and mode decode.
  sdu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .line_mode_i (s_axis_tuser),
    .item_o      (item),
    .bpp_idx_o   (bpp_idx),
    .restart_o   (restart)
  );

  // Previous line store.
  sdu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (item.col),
    .rdata_o (above_rdata)
  );

  // Reconstruction and result register.
  sdu_recon u_recon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item),
    .bpp_idx_i     (bpp_idx),
    .restart_i     (restart),
    .in_ready_o    (s_axis_tready),
    .above_rdata_i (above_rdata),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_byte_o  (m_axis_tdata),
    .end_of_line_o (m_axis_tlast),
    .bad_mode_o    (bad_mode)
  );

  assign m_axis_tuser = bad_mode;

endmodule
